/* rtl/ipv4dq_pkg.sv */
// Shared types, codes and parse helpers for the dotted-quad IPv4 checker.
package ipv4dq_pkg;

   // Character codes and limits
   localparam logic [7:0] DOT_CODE    = 8'd46;
   localparam logic [7:0] ZERO_CODE   = 8'd48;
   localparam logic [8:0] MAX_OCTET   = 9'd255;
   localparam logic [8:0] SAT_VALUE   = 9'd256;
   localparam logic [8:0] CLASS_A_TOP = 9'd127;
   localparam logic [8:0] CLASS_B_TOP = 9'd191;
   localparam logic [8:0] CLASS_C_TOP = 9'd223;
   localparam logic [8:0] CLASS_D_TOP = 9'd239;

   // Saturation points of the counters
   localparam logic [2:0] DOT_SAT    = 3'd4;
   localparam logic [2:0] CELL_SAT   = 3'd5;
   localparam logic [2:0] CELL_STORE = 3'd4;
   localparam logic [1:0] LEN_SAT    = 2'd2;
   localparam logic [2:0] DOTS_NEED  = 3'd3;
   localparam logic [2:0] CELLS_NEED = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_SYMBOL = 3'd1;
   localparam logic [2:0] ERR_CELL_COUNT = 3'd2;
   localparam logic [2:0] ERR_OVER_RANGE = 3'd3;
   localparam logic [2:0] ERR_NONDIGIT   = 3'd4;
   localparam logic [2:0] ERR_LEAD_ZERO  = 3'd5;

   // Class codes
   localparam logic [2:0] CLASS_A = 3'd0;
   localparam logic [2:0] CLASS_B = 3'd1;
   localparam logic [2:0] CLASS_C = 3'd2;
   localparam logic [2:0] CLASS_D = 3'd3;
   localparam logic [2:0] CLASS_E = 3'd4;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic       addr_ok;
      logic [2:0] error_code;
      logic [7:0] octet_a;
      logic [7:0] octet_b;
      logic [7:0] octet_c;
      logic [7:0] octet_d;
      logic [2:0] addr_class;
      logic [1:0] network_cells;
   } rsp_type;

   // Running parse state of one address
   typedef struct packed {
      logic [2:0]      dot_total;
      logic [2:0]      cell_total;
      logic [8:0]      cell_value;
      logic [1:0]      cell_length;
      logic            digits_ended;
      logic            first_is_zero;
      logic [3:0][8:0] octet_store;
      logic            flag_bad_symbol;
      logic            flag_nondigit;
      logic            flag_leading_zero;
      logic            flag_over_range;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '0;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch inside {[8'd48:8'd57]});
   endfunction

   function automatic logic is_allowed(input logic [7:0] ch);
      return (ch inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122],
                         8'd32, [8'd9:8'd13], DOT_CODE});
   endfunction

   // Close the current cell: store it, count it, fold its flags in
   function automatic parse_state_type close_cell(input parse_state_type s);
      parse_state_type r;
      r = s;
      if (s.cell_length != 2'd0) begin
         if (s.cell_total < CELL_STORE) begin
            r.octet_store[s.cell_total[1:0]] = s.cell_value;
         end
         if (s.cell_total < CELL_SAT) begin
            r.cell_total = s.cell_total + 3'd1;
         end
         if (s.digits_ended) begin
            r.flag_nondigit = 1'b1;
         end
         if (s.first_is_zero && s.cell_length >= LEN_SAT) begin
            r.flag_leading_zero = 1'b1;
         end
         if (s.cell_value > MAX_OCTET) begin
            r.flag_over_range = 1'b1;
         end
         r.cell_value    = '0;
         r.cell_length   = '0;
         r.digits_ended  = 1'b0;
         r.first_is_zero = 1'b0;
      end
      return r;
   endfunction

endpackage

/* rtl/ipv4dq_step.sv */
// One-character update of the parse state and the verdict on the final character.
module ipv4dq_step import ipv4dq_pkg::*; (
   input  parse_state_type state_cur,
   input  req_type         beat,
   output parse_state_type state_next,
   output rsp_type         verdict
);

   parse_state_type s;
   parse_state_type fin;
   logic [11:0]     acc;
   logic [2:0]      err;

   // Fold the character into the state
   always_comb begin
      s   = state_cur;
      acc = ({3'b000, state_cur.cell_value} * 12'd10) + {8'h00, beat.char_code[3:0]};
      if (!is_allowed(beat.char_code)) begin
         s.flag_bad_symbol = 1'b1;
      end
      if (beat.char_code == DOT_CODE) begin
         if (s.dot_total < DOT_SAT) begin
            s.dot_total = s.dot_total + 3'd1;
         end
         s = close_cell(s);
      end else begin
         if (s.cell_length == 2'd0 && beat.char_code == ZERO_CODE) begin
            s.first_is_zero = 1'b1;
         end
         if (is_digit(beat.char_code)) begin
            if (!s.digits_ended) begin
               s.cell_value = (acc > {3'b000, SAT_VALUE}) ? SAT_VALUE : acc[8:0];
            end
         end else begin
            s.digits_ended = 1'b1;
         end
         if (s.cell_length < LEN_SAT) begin
            s.cell_length = s.cell_length + 2'd1;
         end
      end
      fin = close_cell(s);
   end

   // Verdict in priority order
   always_comb begin
      if (fin.flag_bad_symbol) begin
         err = ERR_BAD_SYMBOL;
      end else if (fin.cell_total != CELLS_NEED || fin.dot_total != DOTS_NEED) begin
         err = ERR_CELL_COUNT;
      end else if (fin.flag_over_range) begin
         err = ERR_OVER_RANGE;
      end else if (fin.flag_nondigit) begin
         err = ERR_NONDIGIT;
      end else if (fin.flag_leading_zero) begin
         err = ERR_LEAD_ZERO;
      end else begin
         err = ERR_NONE;
      end
   end

   // Result fields; all zero but the error code unless the address is good
   always_comb begin
      verdict            = '0;
      verdict.error_code = err;
      if (err == ERR_NONE) begin
         verdict.addr_ok = 1'b1;
         verdict.octet_a = fin.octet_store[0][7:0];
         verdict.octet_b = fin.octet_store[1][7:0];
         verdict.octet_c = fin.octet_store[2][7:0];
         verdict.octet_d = fin.octet_store[3][7:0];
         if (fin.octet_store[0] <= CLASS_A_TOP) begin
            verdict.addr_class    = CLASS_A;
            verdict.network_cells = 2'd1;
         end else if (fin.octet_store[0] <= CLASS_B_TOP) begin
            verdict.addr_class    = CLASS_B;
            verdict.network_cells = 2'd2;
         end else if (fin.octet_store[0] <= CLASS_C_TOP) begin
            verdict.addr_class    = CLASS_C;
            verdict.network_cells = 2'd3;
         end else if (fin.octet_store[0] <= CLASS_D_TOP) begin
            verdict.addr_class    = CLASS_D;
            verdict.network_cells = 2'd0;
         end else begin
            verdict.addr_class    = CLASS_E;
            verdict.network_cells = 2'd0;
         end
      end
   end

   // Next address starts from reset after the final character
   assign state_next = beat.end_of_text ? PARSE_RESET : s;

endmodule

/* rtl/ipv4_dotted_quad_checker.sv */
// Top level of the dotted-quad IPv4 checker: input register, parse state, result register.
//
//   channel | direction | payload  | handshake
//   req     | in        | req_type | req_valid / req_ready
//   rsp     | out       | rsp_type | rsp_valid / rsp_ready
//
// One character beat per cycle unless a final-character beat waits on a busy result register; the
// held beat's parse-state update commits as it goes through, with its verdict if it is final.
// A final-character beat passes the input register, then the result register, to rsp_valid.
// Reset clears the input and result valids and the parse state at the next clock edge.
// A stalled result holds only final-character beats; other characters keep flowing.
module ipv4_dotted_quad_checker import ipv4dq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic            in_valid_ff;
   req_type         in_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            rsp_valid_ff;
   rsp_type         rsp_ff;
   rsp_type         verdict;
   logic            fire;

   ipv4dq_step u_step (
      .state_cur  (state_ff),
      .beat       (in_ff),
      .state_next (state_in),
      .verdict    (verdict)
   );

   // The held beat goes through unless it needs a busy result register
   assign fire      = in_valid_ff &&
                      (!in_ff.end_of_text || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && in_ff.end_of_text) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire && in_ff.end_of_text) begin
         rsp_ff <= verdict;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A final character always leaves a result and a cleared parse state
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      fire && in_ff.end_of_text |=> rsp_valid_ff && state_ff == PARSE_RESET)
      else $error("final character did not produce result and clear state");

   // An accepted beat is held in the input register next cycle
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted beat lost");

   // A waiting result is never overwritten by a new final character
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(fire && in_ff.end_of_text))
      else $error("result overwritten while stalled");

   // A good verdict carries the no-error code and a matching network count
   a_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.addr_ok |-> rsp_ff.error_code == ERR_NONE &&
      (rsp_ff.addr_class == CLASS_D || rsp_ff.addr_class == CLASS_E ||
       rsp_ff.network_cells == rsp_ff.addr_class[1:0] + 2'd1))
      else $error("inconsistent good verdict");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the dotted-quad IPv4 checker: directed rows, then random addresses.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ipv4dq_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_CHARS = 420;
   localparam int RANDOM_ADDRS = 40;

   // One character beat plus an optional typed-in verdict for it
   typedef struct packed {
      req_type beat;
      logic    pinned;
      rsp_type want;
   } char_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   ipv4_dotted_quad_checker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   char_item_type char_q[$];
   char_item_type drv_item = '0;
   rsp_type       verdict_q[$];
   logic [7:0]    addr_buf[$];
   int            total_chars;
   int            beats_in = 0;
   int            errors_seen = 0;
   int            gap_left = 0;
   int            stall_left = 0;
   int            req_calm = 0;
   int            rsp_calm = 0;

   // Parser mirror: counters, current cell and collected flags
   logic [2:0] dots_seen;
   logic [2:0] cells_seen;
   logic [8:0] run_value;
   logic [1:0] run_len;
   logic       run_broken;
   logic       run_zero_first;
   logic [8:0] octet_q[4];
   logic       saw_bad_char;
   logic       saw_nondigit;
   logic       saw_lead_zero;
   logic       saw_over;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   function automatic logic digit_char(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic logic legal_char(input logic [7:0] ch);
      return digit_char(ch) || (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") ||
             ch == " " || (ch >= 8'd9 && ch <= 8'd13) || ch == DOT_CODE;
   endfunction

   task automatic clear_run();
      run_value      = '0;
      run_len        = '0;
      run_broken     = 1'b0;
      run_zero_first = 1'b0;
   endtask

   task automatic clear_parse();
      dots_seen     = '0;
      cells_seen    = '0;
      saw_bad_char  = 1'b0;
      saw_nondigit  = 1'b0;
      saw_lead_zero = 1'b0;
      saw_over      = 1'b0;
      for (int i = 0; i < 4; i++) octet_q[i] = '0;
      clear_run();
   endtask

   // Close a nonempty cell: store it, count it, fold its flags
   task automatic close_run();
      if (run_len != 2'd0) begin
         if (cells_seen < CELL_STORE) octet_q[cells_seen[1:0]] = run_value;
         if (cells_seen < CELL_SAT) cells_seen = cells_seen + 3'd1;
         if (run_broken) saw_nondigit = 1'b1;
         if (run_zero_first && run_len >= LEN_SAT) saw_lead_zero = 1'b1;
         if (run_value > MAX_OCTET) saw_over = 1'b1;
         clear_run();
      end
   endtask

   // Feed one character; on the last one produce the verdict
   task automatic step_parser(input req_type beat, output logic done, output rsp_type verdict);
      logic [7:0]  ch;
      logic [12:0] acc;
      logic [8:0]  lead;
      ch      = beat.char_code;
      done    = 1'b0;
      verdict = '0;
      if (!legal_char(ch)) saw_bad_char = 1'b1;
      if (ch == DOT_CODE) begin
         if (dots_seen < DOT_SAT) dots_seen = dots_seen + 3'd1;
         close_run();
      end else begin
         if (run_len == 2'd0 && ch == ZERO_CODE) run_zero_first = 1'b1;
         if (digit_char(ch)) begin
            if (!run_broken) begin
               acc = 13'(run_value) * 13'd10 + 13'(ch - ZERO_CODE);
               run_value = (acc > 13'(SAT_VALUE)) ? SAT_VALUE : acc[8:0];
            end
         end else begin
            run_broken = 1'b1;
         end
         if (run_len < LEN_SAT) run_len = run_len + 2'd1;
      end
      if (beat.end_of_text) begin
         close_run();
         done = 1'b1;
         if (saw_bad_char) verdict.error_code = ERR_BAD_SYMBOL;
         else if (cells_seen != CELLS_NEED || dots_seen != DOTS_NEED)
            verdict.error_code = ERR_CELL_COUNT;
         else if (saw_over) verdict.error_code = ERR_OVER_RANGE;
         else if (saw_nondigit) verdict.error_code = ERR_NONDIGIT;
         else if (saw_lead_zero) verdict.error_code = ERR_LEAD_ZERO;
         else verdict.error_code = ERR_NONE;
         if (verdict.error_code == ERR_NONE) begin
            lead = octet_q[0];
            verdict.addr_ok = 1'b1;
            verdict.octet_a = octet_q[0][7:0];
            verdict.octet_b = octet_q[1][7:0];
            verdict.octet_c = octet_q[2][7:0];
            verdict.octet_d = octet_q[3][7:0];
            if (lead <= CLASS_A_TOP) begin
               verdict.addr_class = CLASS_A;
               verdict.network_cells = 2'd1;
            end else if (lead <= CLASS_B_TOP) begin
               verdict.addr_class = CLASS_B;
               verdict.network_cells = 2'd2;
            end else if (lead <= CLASS_C_TOP) begin
               verdict.addr_class = CLASS_C;
               verdict.network_cells = 2'd3;
            end else if (lead <= CLASS_D_TOP) begin
               verdict.addr_class = CLASS_D;
            end else begin
               verdict.addr_class = CLASS_E;
            end
         end
         clear_parse();
      end
   endtask

   function automatic rsp_type make_rsp(input logic ok, input logic [2:0] err,
                                        input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input logic [2:0] cls, input logic [1:0] net);
      rsp_type r;
      r = '{addr_ok: ok, error_code: err, octet_a: a, octet_b: b, octet_c: c, octet_d: d,
            addr_class: cls, network_cells: net};
      return r;
   endfunction

   // Queue a whole address; only its final character carries end_of_text
   task automatic queue_text(input logic pinned, input rsp_type want);
      char_item_type item;
      foreach (addr_buf[i]) begin
         item.beat.char_code   = addr_buf[i];
         item.beat.end_of_text = (i == addr_buf.size() - 1);
         item.pinned           = pinned && item.beat.end_of_text;
         item.want             = want;
         char_q.push_back(item);
      end
   endtask

   task automatic add_row(input string body, input logic [7:0] last_ch,
                          input logic pinned, input rsp_type want);
      addr_buf.delete();
      for (int i = 0; i < body.len(); i++) addr_buf.push_back(body[i]);
      addr_buf.push_back(last_ch);
      queue_text(pinned, want);
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'(ZERO_CODE + 8'($urandom_range(0, 9)));
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(65, 90))
                                         : 8'($urandom_range(97, 122));
   endfunction

   function automatic logic [7:0] rand_blank();
      return ($urandom_range(0, 1) != 0) ? 8'd32 : 8'($urandom_range(9, 13));
   endfunction

   // Codes outside the allowed set
   function automatic logic [7:0] rand_bad();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 8));
         1: return 8'($urandom_range(14, 31));
         2: return 8'($urandom_range(33, 45));
         3: return ($urandom_range(0, 1) != 0) ? 8'd47 : 8'($urandom_range(58, 64));
         4: return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(91, 96))
                                               : 8'($urandom_range(123, 127));
         default: return 8'($urandom_range(128, 255));
      endcase
   endfunction

   function automatic int boundary_octet();
      int marks[13] = '{0, 1, 126, 127, 128, 191, 192, 223, 224, 239, 240, 254, 255};
      return marks[$urandom_range(0, 12)];
   endfunction

   task automatic push_number(input int v);
      if (v >= 100) addr_buf.push_back(8'(ZERO_CODE + 8'(v / 100)));
      if (v >= 10) addr_buf.push_back(8'(ZERO_CODE + 8'((v / 10) % 10)));
      addr_buf.push_back(8'(ZERO_CODE + 8'(v % 10)));
   endtask

   // One cell of a dotted address, well formed most of the time
   task automatic gen_cell(input logic first);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if (first && $urandom_range(0, 2) == 0) push_number(boundary_octet());
         else push_number($urandom_range(0, 255));
      end else if (pick < 57) begin
         addr_buf.push_back(ZERO_CODE);
      end else if (pick < 65) begin
         // over 255, sometimes far beyond saturation
         if ($urandom_range(0, 2) == 0) begin
            addr_buf.push_back(8'(ZERO_CODE + 8'($urandom_range(1, 9))));
            repeat ($urandom_range(3, 5)) addr_buf.push_back(rand_digit());
         end else begin
            push_number($urandom_range(256, 999));
         end
      end else if (pick < 72) begin
         addr_buf.push_back(ZERO_CODE);
         repeat ($urandom_range(1, 2)) addr_buf.push_back(rand_digit());
      end else if (pick < 81) begin
         // digit run broken by a letter or blank, maybe one more digit after
         if ($urandom_range(0, 3) != 0) push_number($urandom_range(0, 255));
         addr_buf.push_back(($urandom_range(0, 1) != 0) ? rand_letter() : rand_blank());
         if ($urandom_range(0, 1) != 0) addr_buf.push_back(rand_digit());
      end else if (pick < 87) begin
         // empty cell
      end else if (pick < 92) begin
         addr_buf.push_back(rand_bad());
         addr_buf.push_back(rand_digit());
      end else begin
         repeat ($urandom_range(1, 4)) addr_buf.push_back(rand_digit());
      end
   endtask

   task automatic gen_address();
      int kind;
      int cells;
      int pick;
      addr_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
         pick  = $urandom_range(0, 99);
         cells = (pick < 80) ? 4 : (pick < 88) ? 3 : (pick < 96) ? 5 : 6;
         if ($urandom_range(0, 19) == 0) addr_buf.push_back(DOT_CODE);
         for (int i = 0; i < cells; i++) begin
            if (i > 0) addr_buf.push_back(DOT_CODE);
            gen_cell(i == 0);
         end
         if ($urandom_range(0, 19) == 0) addr_buf.push_back(DOT_CODE);
      end else if (kind < 88) begin
         repeat ($urandom_range(1, 16)) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) addr_buf.push_back(rand_digit());
            else if (pick < 65) addr_buf.push_back(DOT_CODE);
            else if (pick < 80) addr_buf.push_back(rand_letter());
            else if (pick < 90) addr_buf.push_back(rand_blank());
            else addr_buf.push_back(rand_bad());
         end
      end else begin
         repeat ($urandom_range(1, 6)) addr_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (addr_buf.size() == 0) addr_buf.push_back(rand_digit());
      queue_text(1'b0, '0);
   endtask

   // Idle length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_idle(inout int calm);
      int pick;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors_seen++;
      end
   endtask

   // Request side: hold a beat until it is taken, then idle or send the next
   always @(posedge clock) begin : drive_req
      char_item_type item;
      if (!reset && (!req_valid || req_ready)) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (char_q.size() != 0) begin
            item = char_q.pop_front();
            drv_item  <= item;
            req_data  <= item.beat;
            req_valid <= 1'b1;
            gap_left  <= pick_idle(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= pick_idle(rsp_calm);
      end
   end

   // Check result beats, then predict from accepted character beats
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type got;
      logic    done;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         if (verdict_q.size() == 0) begin
            $error("result beat with no verdict pending");
            errors_seen++;
         end else begin
            want = verdict_q.pop_front();
            check_field("addr_ok", int'(want.addr_ok), int'(got.addr_ok));
            check_field("error_code", int'(want.error_code), int'(got.error_code));
            check_field("octet_a", int'(want.octet_a), int'(got.octet_a));
            check_field("octet_b", int'(want.octet_b), int'(got.octet_b));
            check_field("octet_c", int'(want.octet_c), int'(got.octet_c));
            check_field("octet_d", int'(want.octet_d), int'(got.octet_d));
            check_field("addr_class", int'(want.addr_class), int'(got.addr_class));
            check_field("network_cells", int'(want.network_cells),
                        int'(got.network_cells));
         end
      end
      if (!reset && req_valid && req_ready) begin
         step_parser(drv_item.beat, done, want);
         if (done) verdict_q.push_back(drv_item.pinned ? drv_item.want : want);
         beats_in++;
      end
   end

   initial begin
      int addrs;
      clear_parse();

      // Directed rows: text, final character, typed-in verdict where obvious
      add_row("0.0.0.", "0", 1'b1,
              make_rsp(1'b1, ERR_NONE, 8'd0, 8'd0, 8'd0, 8'd0, CLASS_A, 2'd1));
      add_row("", 8'hFF, 1'b1,
              make_rsp(1'b0, ERR_BAD_SYMBOL, 8'd0, 8'd0, 8'd0, 8'd0, CLASS_A, 2'd0));
      add_row("", 8'h00, 1'b1,
              make_rsp(1'b0, ERR_BAD_SYMBOL, 8'd0, 8'd0, 8'd0, 8'd0, CLASS_A, 2'd0));
      add_row("", DOT_CODE, 1'b1,
              make_rsp(1'b0, ERR_CELL_COUNT, 8'd0, 8'd0, 8'd0, 8'd0, CLASS_A, 2'd0));
      add_row("240.9.1.25", "5", 1'b1,
              make_rsp(1'b1, ERR_NONE, 8'd240, 8'd9, 8'd1, 8'd255, CLASS_E, 2'd0));
      add_row("9.8.7.6 ", 8'd13, 1'b0, '0);

      // Random addresses
      total_chars = char_q.size();
      addrs = 0;
      while (char_q.size() - total_chars < RANDOM_CHARS || addrs < RANDOM_ADDRS) begin
         gen_address();
         addrs++;
      end
      total_chars = char_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (beats_in < total_chars) @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors_seen == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ipv4dq_pkg.sv
rtl/ipv4dq_step.sv
rtl/ipv4_dotted_quad_checker.sv
verif/tb_top.sv
